@@ hw/rtl/fh64_pkg.sv @@
// Package for the streaming fasthash64 block: hash constants, mixing functions,
// and the command and status types shared by the controller and the datapath.
// Depends on nothing.
package fh64_pkg;

    localparam logic [63:0] MUL_ACC = 64'h880355f21e6d1965;
    localparam logic [63:0] MUL_MIX = 64'h2127599bf4325c37;
    localparam int unsigned SHIFT_PRE  = 23;
    localparam int unsigned SHIFT_POST = 47;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_PP0,
        MUL_PP1,
        MUL_PP2
    } mul_step_t;

    typedef enum logic {
        CONST_ACC,
        CONST_MIX
    } const_sel_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LEN,
        OP_WORD_PRE,
        OP_ACC_PRE,
        OP_FOLD,
        OP_PROD_PRE
    } op_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_SEED,
        ACC_FOLD,
        ACC_PROD
    } acc_sel_t;

    typedef struct packed {
        logic       capture;
        mul_step_t  mul_step;
        const_sel_t const_sel;
        op_sel_t    op_sel;
        acc_sel_t   acc_sel;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic word_nz;
        logic last;
        logic out_busy;
    } dp_status_t;

    function automatic logic [63:0] pre_mix(input logic [63:0] x);
        pre_mix = x ^ (x >> SHIFT_PRE);
    endfunction

    function automatic logic [63:0] post_mix(input logic [63:0] x);
        post_mix = x ^ (x >> SHIFT_POST);
    endfunction

endpackage

@@ hw/rtl/fh64_in_if.sv @@
// Input channel of the fasthash64 block: valid/ready handshake with one message word.
// Depends on nothing.
interface fh64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic [31:0] message_length;
    logic [63:0] hash_seed;
    logic        last_word;

    modport source (
        output valid, data_word, byte_count, message_length, hash_seed, last_word,
        input  ready
    );

    modport sink (
        input  valid, data_word, byte_count, message_length, hash_seed, last_word,
        output ready
    );
endinterface

@@ hw/rtl/fh64_out_if.sv @@
// Output channel of the fasthash64 block: valid/ready handshake with one digest.
// Depends on nothing.
interface fh64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;

    modport source (
        output valid, digest,
        input  ready
    );

    modport sink (
        input  valid, digest,
        output ready
    );
endinterface

@@ hw/rtl/fh64_ctrl.sv @@
// Controller of the fasthash64 block: sequences the shared multiplier and the
// accumulator updates for each input transaction.
// Depends on fh64_pkg.
module fh64_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fh64_pkg::dp_status_t status,
    output fh64_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_LEN0,
        S_LEN1,
        S_LEN2,
        S_SEED,
        S_CHECK,
        S_W0,
        S_W1,
        S_W2,
        S_WFOLD,
        S_A0,
        S_A1,
        S_A2,
        S_AWB,
        S_F0,
        S_F1,
        S_F2,
        S_FOUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_msg_reg, in_msg_next;

    always_comb
    begin
        state_next        = state_reg;
        in_msg_next       = in_msg_reg;
        in_ready          = 1'b0;
        cmd.capture       = 1'b0;
        cmd.mul_step      = fh64_pkg::MUL_IDLE;
        cmd.const_sel     = fh64_pkg::CONST_ACC;
        cmd.op_sel        = fh64_pkg::OP_HOLD;
        cmd.acc_sel       = fh64_pkg::ACC_HOLD;
        cmd.out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.op_sel  = fh64_pkg::OP_LEN;
                    state_next  = in_msg_reg ? S_CHECK : S_LEN0;
                end
            end
            S_LEN0:
            begin
                cmd.mul_step = fh64_pkg::MUL_PP0;
                state_next   = S_LEN1;
            end
            S_LEN1:
            begin
                cmd.mul_step = fh64_pkg::MUL_PP1;
                state_next   = S_LEN2;
            end
            S_LEN2:
            begin
                cmd.mul_step = fh64_pkg::MUL_PP2;
                state_next   = S_SEED;
            end
            S_SEED:
            begin
                cmd.acc_sel = fh64_pkg::ACC_SEED;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                in_msg_next = !status.last;
                if (status.word_nz)
                begin
                    cmd.op_sel = fh64_pkg::OP_WORD_PRE;
                    state_next = S_W0;
                end
                else if (status.last)
                begin
                    cmd.op_sel = fh64_pkg::OP_ACC_PRE;
                    state_next = S_F0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_W0:
            begin
                cmd.mul_step  = fh64_pkg::MUL_PP0;
                cmd.const_sel = fh64_pkg::CONST_MIX;
                state_next    = S_W1;
            end
            S_W1:
            begin
                cmd.mul_step  = fh64_pkg::MUL_PP1;
                cmd.const_sel = fh64_pkg::CONST_MIX;
                state_next    = S_W2;
            end
            S_W2:
            begin
                cmd.mul_step  = fh64_pkg::MUL_PP2;
                cmd.const_sel = fh64_pkg::CONST_MIX;
                state_next    = S_WFOLD;
            end
            S_WFOLD:
            begin
                cmd.acc_sel = fh64_pkg::ACC_FOLD;
                cmd.op_sel  = fh64_pkg::OP_FOLD;
                state_next  = S_A0;
            end
            S_A0:
            begin
                cmd.mul_step = fh64_pkg::MUL_PP0;
                state_next   = S_A1;
            end
            S_A1:
            begin
                cmd.mul_step = fh64_pkg::MUL_PP1;
                state_next   = S_A2;
            end
            S_A2:
            begin
                cmd.mul_step = fh64_pkg::MUL_PP2;
                state_next   = S_AWB;
            end
            S_AWB:
            begin
                cmd.acc_sel = fh64_pkg::ACC_PROD;
                if (status.last)
                begin
                    cmd.op_sel = fh64_pkg::OP_PROD_PRE;
                    state_next = S_F0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_F0:
            begin
                cmd.mul_step  = fh64_pkg::MUL_PP0;
                cmd.const_sel = fh64_pkg::CONST_MIX;
                state_next    = S_F1;
            end
            S_F1:
            begin
                cmd.mul_step  = fh64_pkg::MUL_PP1;
                cmd.const_sel = fh64_pkg::CONST_MIX;
                state_next    = S_F2;
            end
            S_F2:
            begin
                cmd.mul_step  = fh64_pkg::MUL_PP2;
                cmd.const_sel = fh64_pkg::CONST_MIX;
                state_next    = S_FOUT;
            end
            S_FOUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            in_msg_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

@@ hw/rtl/fh64_datapath.sv @@
// Datapath of the fasthash64 block: input capture, byte masking, a shared 32x32
// multiplier that builds 64-bit products in three steps, accumulator and digest register.
// Depends on fh64_pkg.
module fh64_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fh64_pkg::dp_cmd_t    cmd,
    output fh64_pkg::dp_status_t status,
    input  logic [63:0]          data_word,
    input  logic [3:0]           byte_count,
    input  logic [31:0]          message_length,
    input  logic [63:0]          hash_seed,
    input  logic                 last_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          digest
);

    logic [63:0] word_reg, seed_reg, op_reg, prod_reg, acc_reg, digest_reg;
    logic [63:0] op_next, prod_next, acc_next, digest_next;
    logic        nz_reg, last_reg, out_valid_reg;
    logic        nz_next, last_next, out_valid_next;
    logic [63:0] byte_mask, fold_value;
    logic [63:0] mul_const;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_mask[i*8 +: 8] = (byte_count > 4'(i)) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        mul_const = (cmd.const_sel == fh64_pkg::CONST_MIX) ? fh64_pkg::MUL_MIX
                                                           : fh64_pkg::MUL_ACC;
        mul_a = (cmd.mul_step == fh64_pkg::MUL_PP1) ? op_reg[63:32] : op_reg[31:0];
        mul_b = (cmd.mul_step == fh64_pkg::MUL_PP2) ? mul_const[63:32] : mul_const[31:0];
        mul_p = {32'b0, mul_a} * {32'b0, mul_b};
        prod_next = prod_reg;
        case (cmd.mul_step) inside
            fh64_pkg::MUL_PP0:
            begin
                prod_next = mul_p;
            end
            fh64_pkg::MUL_PP1, fh64_pkg::MUL_PP2:
            begin
                prod_next = {prod_reg[63:32] + mul_p[31:0], prod_reg[31:0]};
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_comb
    begin
        fold_value = acc_reg ^ fh64_pkg::post_mix(prod_reg);
        op_next    = op_reg;
        case (cmd.op_sel)
            fh64_pkg::OP_LEN:      op_next = {32'b0, message_length};
            fh64_pkg::OP_WORD_PRE: op_next = fh64_pkg::pre_mix(word_reg);
            fh64_pkg::OP_ACC_PRE:  op_next = fh64_pkg::pre_mix(acc_reg);
            fh64_pkg::OP_FOLD:     op_next = fold_value;
            fh64_pkg::OP_PROD_PRE: op_next = fh64_pkg::pre_mix(prod_reg);
            default:               op_next = op_reg;
        endcase
        acc_next = acc_reg;
        case (cmd.acc_sel)
            fh64_pkg::ACC_SEED: acc_next = seed_reg ^ prod_reg;
            fh64_pkg::ACC_FOLD: acc_next = fold_value;
            fh64_pkg::ACC_PROD: acc_next = prod_reg;
            default:            acc_next = acc_reg;
        endcase
        nz_next        = cmd.capture ? (byte_count != 4'd0) : nz_reg;
        last_next      = cmd.capture ? last_word : last_reg;
        digest_next    = cmd.out_load ? fh64_pkg::post_mix(prod_reg) : digest_reg;
        out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg        <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 64'b0;
        end
        else
        begin
            nz_reg        <= nz_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_reg <= data_word & byte_mask;
            seed_reg <= hash_seed;
        end
        op_reg     <= op_next;
        prod_reg   <= prod_next;
        digest_reg <= digest_next;
    end

    assign status.word_nz  = nz_reg;
    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg & ~out_ready;
    assign out_valid       = out_valid_reg;
    assign digest          = digest_reg;

endmodule

@@ hw/rtl/streaming_fast_hash64_top.sv @@
// Streaming fasthash64 top level: controller and datapath joined by command and status.
// A word is accepted only when idle, after the previous word is done. The first word of a
// message also multiplies the length and seeds the accumulator; a word with a byte count of
// zero skips both word multiplies; a last word adds a final multiply, and its digest is
// registered once no earlier digest waits. Each 64-bit multiply is three 32x32 steps.
// Reset is asynchronous and active low; it clears the controller, accumulator and output valid.
module streaming_fast_hash64_top (
    input  logic             clk,
    input  logic             rst_n,
    fh64_in_if.sink          in_ch,
    fh64_out_if.source       out_ch
);

    fh64_pkg::dp_cmd_t    cmd;
    fh64_pkg::dp_status_t status;

    fh64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    fh64_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .data_word      (in_ch.data_word),
        .byte_count     (in_ch.byte_count),
        .message_length (in_ch.message_length),
        .hash_seed      (in_ch.hash_seed),
        .last_word      (in_ch.last_word),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .digest         (out_ch.digest)
    );

    // The block is busy right after every accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input ready right after an accepted transaction");

    // A new digest is only produced while a transaction is being processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(!in_ch.ready))
        else $error("digest appeared while the block was idle");

    // A pending digest stays valid and unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.digest)))
        else $error("pending digest dropped or changed");

endmodule
